// File: src/bnf_pkg.sv
// ----------------------------------------------------------------------------
// bnf_pkg: shared definitions for the batch-normalisation forward block
// Default sizes, operation codes, status codes and field widths.
// ----------------------------------------------------------------------------
package bnf_pkg;

    localparam int STORE_DEPTH_DEF  = 4096;
    localparam int MAX_CHANNELS_DEF = 64;

    localparam int OP_W     = 2;
    localparam int POS_W    = 12;
    localparam int SAMPLE_W = 16;
    localparam int NORM_W   = 16;
    localparam int AVG_W    = 16;
    localparam int SPREAD_W = 32;
    localparam int STATUS_W = 2;
    localparam int BATCH_W  = 13;
    localparam int CHAN_W   = 7;
    localparam int SPAT_W   = 13;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    // Square root operand and result widths
    localparam int ROOT_IN_W  = 64;
    localparam int ROOT_OUT_W = 32;

    localparam logic [OP_W-1:0] OP_LOAD    = 2'd0;
    localparam logic [OP_W-1:0] OP_COMPUTE = 2'd1;
    localparam logic [OP_W-1:0] OP_READ    = 2'd2;
    localparam logic [OP_W-1:0] OP_NOP     = 2'd3;

    localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_STATS  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_POS   = 2'd2;
    localparam logic [STATUS_W-1:0] ST_CAPACITY  = 2'd3;

    localparam logic [CFG_IDX_W-1:0] REG_BATCH   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SPATIAL = 2'd2;

    typedef struct packed {
        logic start;
        logic done;
    } bnf_unit_ctl_t;

endpackage

// File: src/bnf_div.sv
// ----------------------------------------------------------------------------
// bnf_div: restoring serial divider
// One quotient bit per cycle; quotient and remainder hold until next start.
// ----------------------------------------------------------------------------
module bnf_div #(
    parameter int NUM_W = 48,
    parameter int DEN_W = 34
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic [NUM_W-1:0] num,
    input  logic [DEN_W-1:0] den,
    output logic             done,
    output logic [NUM_W-1:0] quot,
    output logic [DEN_W-1:0] rem
);

    localparam int CNT_W = $clog2(NUM_W + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [NUM_W-1:0] q_reg;
    logic [DEN_W-1:0] rem_reg;
    logic [DEN_W-1:0] den_reg;

    logic [DEN_W:0]   trial;
    logic             fits;
    logic [DEN_W:0]   diff;

    always_comb begin
        trial = {rem_reg, q_reg[NUM_W-1]};
        fits  = trial >= {1'b0, den_reg};
        diff  = trial - {1'b0, den_reg};
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(NUM_W);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start && !busy_reg) begin
            q_reg   <= num;
            rem_reg <= '0;
            den_reg <= den;
        end else if (busy_reg) begin
            q_reg   <= {q_reg[NUM_W-2:0], fits};
            rem_reg <= fits ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
        end
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = rem_reg;

endmodule

// File: src/bnf_sqrt.sv
// ----------------------------------------------------------------------------
// bnf_sqrt: digit-by-digit integer square root
// Two operand bits per cycle; the result is the floor of the root.
// ----------------------------------------------------------------------------
module bnf_sqrt (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  bnf_pkg::bnf_unit_ctl_t          ctl_in,
    input  logic [bnf_pkg::ROOT_IN_W-1:0]   value,
    output bnf_pkg::bnf_unit_ctl_t          ctl_out,
    output logic [bnf_pkg::ROOT_OUT_W-1:0]  root
);

    localparam int RW    = bnf_pkg::ROOT_OUT_W;
    localparam int VW    = bnf_pkg::ROOT_IN_W;
    localparam int REM_W = RW + 4;
    localparam int CNT_W = $clog2(RW + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic [VW-1:0]    val_reg;
    logic [REM_W-1:0] rem_reg;
    logic [RW-1:0]    root_reg;

    logic [REM_W-1:0] rem_sh;
    logic [REM_W-1:0] trial;
    logic             fits;

    always_comb begin
        rem_sh = {rem_reg[REM_W-3:0], val_reg[VW-1:VW-2]};
        trial  = {2'b00, root_reg, 2'b01};
        fits   = rem_sh >= trial;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end else begin
            done_reg <= 1'b0;
            if (ctl_in.start && !busy_reg) begin
                busy_reg <= 1'b1;
                cnt_reg  <= CNT_W'(RW);
            end else if (busy_reg) begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == CNT_W'(1)) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (ctl_in.start && !busy_reg) begin
            val_reg  <= value;
            rem_reg  <= '0;
            root_reg <= '0;
        end else if (busy_reg) begin
            val_reg  <= {val_reg[VW-3:0], 2'b00};
            rem_reg  <= fits ? (rem_sh - trial) : rem_sh;
            root_reg <= {root_reg[RW-2:0], fits};
        end
    end

    always_comb begin
        ctl_out.start = busy_reg;
        ctl_out.done  = done_reg;
    end
    assign root = root_reg;

endmodule

// File: src/batch_norm_forward_top.sv
// ----------------------------------------------------------------------------
// batch_norm_forward_top: batch-normalisation forward pass
// Sample store, per-channel statistics tables and the sequencer around them.
// ----------------------------------------------------------------------------
// Usage: write batch_count, channel_count and spatial_count through the cfg
// channel (the block drops s_ready after each write while the tensor size is
// rebuilt), load every position with a load item, send one compute item, then
// read items return (x - mean) / sqrt(var + eps) in Q4.12 together with the
// channel mean (Q8.8) and variance (Q16.16). Loads and errors go from accept
// straight to the emit state. A compute item walks the sample store twice per
// channel through its single read port, one element a cycle, and runs two
// 48-step serial divisions per channel. A read item runs three serial
// divisions and a 32-step square root in sequence. One item is worked on at a
// time; the next item is accepted as soon as the previous result sits in the
// output register, even if it has not been taken yet.
// ----------------------------------------------------------------------------
module batch_norm_forward_top #(
    parameter int STORE_DEPTH  = bnf_pkg::STORE_DEPTH_DEF,
    parameter int MAX_CHANNELS = bnf_pkg::MAX_CHANNELS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    // configuration write channel
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [bnf_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [bnf_pkg::CFG_DATA_W-1:0]    cfg_data,
    // input item channel
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic [bnf_pkg::OP_W-1:0]          s_operation,
    input  logic [bnf_pkg::POS_W-1:0]         s_position,
    input  logic signed [bnf_pkg::SAMPLE_W-1:0] s_sample,
    // result item channel
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [bnf_pkg::NORM_W-1:0] m_normalized,
    output logic signed [bnf_pkg::AVG_W-1:0]  m_channel_average,
    output logic [bnf_pkg::SPREAD_W-1:0]      m_channel_spread,
    output logic [bnf_pkg::STATUS_W-1:0]      m_status
);

    localparam int AW    = $clog2(STORE_DEPTH);
    localparam int CW    = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
    localparam int SUM_W = 17 + AW;
    localparam int SQ_W  = 34 + AW;
    localparam int NUM_W = (SQ_W + 2 > 46) ? SQ_W + 2 : 46;
    localparam int DEN_W = (AW + 3 > 34) ? AW + 3 : 34;
    localparam int BS_W  = bnf_pkg::BATCH_W + bnf_pkg::SPAT_W;
    localparam int CS_W  = bnf_pkg::CHAN_W + bnf_pkg::SPAT_W;
    localparam int TOT_W = BS_W + bnf_pkg::CHAN_W;

    // sequencer states
    localparam logic [3:0] S_IDLE     = 4'd0;
    localparam logic [3:0] S_EMIT     = 4'd1;
    localparam logic [3:0] S_RD_QUOT  = 4'd2;
    localparam logic [3:0] S_RD_CHAN  = 4'd3;
    localparam logic [3:0] S_RD_FETCH = 4'd4;
    localparam logic [3:0] S_RD_ROOT  = 4'd5;
    localparam logic [3:0] S_RD_NORM  = 4'd6;
    localparam logic [3:0] S_CP_SUM   = 4'd7;
    localparam logic [3:0] S_CP_SUMD  = 4'd8;
    localparam logic [3:0] S_CP_MDIV  = 4'd9;
    localparam logic [3:0] S_CP_SQ    = 4'd10;
    localparam logic [3:0] S_CP_SQD   = 4'd11;
    localparam logic [3:0] S_CP_VDIV  = 4'd12;

    // ------------------------------------------------------------------
    // configuration and derived tensor size
    // ------------------------------------------------------------------
    logic [bnf_pkg::BATCH_W-1:0] batch_reg;
    logic [bnf_pkg::CHAN_W-1:0]  chan_reg;
    logic [bnf_pkg::SPAT_W-1:0]  spat_reg;
    logic [BS_W-1:0]             bs_reg;
    logic [CS_W-1:0]             cs_reg;
    logic [TOT_W-1:0]            total_reg;
    logic [1:0]                  settle_reg;
    logic                        stats_ready_reg;

    logic cfg_fire;
    logic cfg_known;

    assign cfg_ready = 1'b1;
    assign cfg_fire  = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index == bnf_pkg::REG_BATCH) ||
                       (cfg_index == bnf_pkg::REG_CHANNEL) ||
                       (cfg_index == bnf_pkg::REG_SPATIAL);

    // size products are registered in order: B*S and C*S first, then B*S*C
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            batch_reg  <= bnf_pkg::BATCH_W'(1);
            chan_reg   <= bnf_pkg::CHAN_W'(1);
            spat_reg   <= bnf_pkg::SPAT_W'(1);
            bs_reg     <= BS_W'(1);
            cs_reg     <= CS_W'(1);
            total_reg  <= TOT_W'(1);
            settle_reg <= 2'd0;
        end else begin
            bs_reg    <= batch_reg * spat_reg;
            cs_reg    <= chan_reg * spat_reg;
            total_reg <= bs_reg * chan_reg;
            if (settle_reg != 2'd0) begin
                settle_reg <= settle_reg - 2'd1;
            end
            if (cfg_fire) begin
                settle_reg <= 2'd2;
                case (cfg_index)
                    bnf_pkg::REG_BATCH:   batch_reg <= cfg_data[bnf_pkg::BATCH_W-1:0];
                    bnf_pkg::REG_CHANNEL: chan_reg  <= cfg_data[bnf_pkg::CHAN_W-1:0];
                    bnf_pkg::REG_SPATIAL: spat_reg  <= cfg_data[bnf_pkg::SPAT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    logic over_cap;
    logic pos_out;
    assign over_cap = (total_reg > TOT_W'(STORE_DEPTH)) ||
                      (32'(chan_reg) > 32'(MAX_CHANNELS));
    assign pos_out  = TOT_W'(s_position) >= total_reg;

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    logic [3:0] state_reg;
    logic       in_fire;

    assign s_ready = (state_reg == S_IDLE) && (settle_reg == 2'd0);
    assign in_fire = s_valid && s_ready;

    // ------------------------------------------------------------------
    // sample store: one write port (loads), one registered read port
    // ------------------------------------------------------------------
    logic [SAMPLE_W_L-1:0] store_mem [STORE_DEPTH];
    localparam int SAMPLE_W_L = bnf_pkg::SAMPLE_W;

    logic [AW+bnf_pkg::POS_W-1:0] pos_wide;
    logic [AW-1:0]                pos_addr;
    logic                         st_we;
    logic [AW-1:0]                st_raddr;
    logic [SAMPLE_W_L-1:0]        store_q_reg;

    logic [AW-1:0] rd_addr_reg;
    logic [AW-1:0] row_base_reg;
    logic [AW-1:0] chan_base_reg;
    logic [bnf_pkg::SPAT_W-1:0]  s_cnt_reg;
    logic [bnf_pkg::BATCH_W-1:0] b_cnt_reg;

    assign pos_wide = {{AW{1'b0}}, s_position};
    assign pos_addr = pos_wide[AW-1:0];
    assign st_we    = in_fire && (s_operation == bnf_pkg::OP_LOAD) && !over_cap && !pos_out;
    assign st_raddr = (state_reg == S_RD_CHAN) ? rd_addr_reg
                                               : row_base_reg + AW'(s_cnt_reg);

    always_ff @(posedge aclk) begin
        if (st_we) begin
            store_mem[pos_addr] <= s_sample;
        end
        store_q_reg <= store_mem[st_raddr];
    end

    // ------------------------------------------------------------------
    // statistics tables, written once per channel by compute
    // ------------------------------------------------------------------
    logic [bnf_pkg::AVG_W-1:0]    mean_mem [MAX_CHANNELS];
    logic [bnf_pkg::SPREAD_W-1:0] var_mem  [MAX_CHANNELS];
    logic [bnf_pkg::AVG_W-1:0]    mean_q_reg;
    logic [bnf_pkg::SPREAD_W-1:0] var_q_reg;
    logic                         tab_we;
    logic [CW-1:0]                tab_waddr;
    logic [CW-1:0]                tab_raddr;
    logic [bnf_pkg::AVG_W-1:0]    mean_val_reg;
    logic [bnf_pkg::SPREAD_W-1:0] var_sat;

    logic [bnf_pkg::CHAN_W-1:0] ch_reg;

    // serial divider
    logic             div_start;
    logic [NUM_W-1:0] div_num;
    logic [DEN_W-1:0] div_den;
    logic             div_done;
    logic [NUM_W-1:0] div_quot;
    logic [DEN_W-1:0] div_rem;

    bnf_div #(
        .NUM_W (NUM_W),
        .DEN_W (DEN_W)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .num     (div_num),
        .den     (div_den),
        .done    (div_done),
        .quot    (div_quot),
        .rem     (div_rem)
    );

    assign tab_raddr = div_rem[CW-1:0];
    assign tab_waddr = CW'(ch_reg);
    assign tab_we    = (state_reg == S_CP_VDIV) && div_done;
    assign var_sat   = (|div_quot[NUM_W-1:bnf_pkg::SPREAD_W]) ? '1
                                                            : div_quot[bnf_pkg::SPREAD_W-1:0];

    always_ff @(posedge aclk) begin
        if (tab_we) begin
            mean_mem[tab_waddr] <= mean_val_reg;
            var_mem[tab_waddr]  <= var_sat;
        end
        mean_q_reg <= mean_mem[tab_raddr];
        var_q_reg  <= var_mem[tab_raddr];
    end

    // square root unit
    bnf_pkg::bnf_unit_ctl_t       root_ctl_in;
    bnf_pkg::bnf_unit_ctl_t       root_ctl_out;
    logic [bnf_pkg::ROOT_IN_W-1:0]  root_val;
    logic [bnf_pkg::ROOT_OUT_W-1:0] root_out;

    bnf_sqrt u_sqrt (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl_in  (root_ctl_in),
        .value   (root_val),
        .ctl_out (root_ctl_out),
        .root    (root_out)
    );

    // ------------------------------------------------------------------
    // datapath registers
    // ------------------------------------------------------------------
    logic                       v1_reg, v2_reg, v3_reg;
    logic signed [SUM_W-1:0]    sum_reg;
    logic [SQ_W-1:0]            sq_acc_reg;
    logic signed [16:0]         d_reg;
    logic [33:0]                prod_reg;
    logic signed [33:0]         prod_full;
    logic [16:0]                d_mag;
    logic [bnf_pkg::AVG_W-1:0]  rd_mean_reg;
    logic [bnf_pkg::SPREAD_W-1:0] rd_var_reg;
    logic [SUM_W-1:0]           sum_mag;
    logic [16:0]                d_fetch;
    logic [15:0]                mean_cur;
    logic                       pipe_idle;
    logic                       row_end;
    logic                       cp_last;
    logic                       cp_issue;
    logic                       sum_pass;
    logic                       sq_pass;

    assign prod_full = d_reg * d_reg;
    assign d_mag     = d_reg[16] ? 17'(-d_reg) : d_reg;
    assign sum_mag   = sum_reg[SUM_W-1] ? SUM_W'(-sum_reg) : SUM_W'(sum_reg);
    assign pipe_idle = !v1_reg && !v2_reg && !v3_reg;
    assign row_end   = s_cnt_reg == spat_reg - 1'b1;
    assign cp_last   = row_end && (b_cnt_reg == batch_reg - 1'b1);
    assign cp_issue  = (state_reg == S_CP_SUM) || (state_reg == S_CP_SQ);
    assign sum_pass  = (state_reg == S_CP_SUM) || (state_reg == S_CP_SUMD);
    assign sq_pass   = (state_reg == S_CP_SQ) || (state_reg == S_CP_SQD);
    // deviation source: channel mean during compute, table mean during read
    assign mean_cur  = (state_reg == S_RD_FETCH) ? mean_q_reg : mean_val_reg;
    assign d_fetch   = {store_q_reg[15], store_q_reg} - {mean_cur[15], mean_cur};
    assign root_val  = {1'b0, 33'(var_q_reg) + 33'd1, 30'd0};

    // divider and root start, operands chosen by state
    always_comb begin
        div_start = 1'b0;
        div_num   = '0;
        div_den   = '0;
        root_ctl_in.start = (state_reg == S_RD_FETCH);
        root_ctl_in.done  = 1'b0;
        case (state_reg)
            S_IDLE: begin
                if (in_fire && (s_operation == bnf_pkg::OP_READ) && !over_cap &&
                    !pos_out && stats_ready_reg) begin
                    div_start = 1'b1;
                    div_num   = NUM_W'(s_position);
                    div_den   = DEN_W'(spat_reg);
                end
            end
            S_RD_QUOT: begin
                div_start = div_done;
                div_num   = NUM_W'(div_quot[bnf_pkg::POS_W-1:0]);
                div_den   = DEN_W'(chan_reg);
            end
            S_RD_ROOT: begin
                div_start = root_ctl_out.done;
                div_num   = NUM_W'({d_mag, 28'd0}) + NUM_W'(root_out);
                div_den   = DEN_W'({root_out, 1'b0});
            end
            S_CP_SUMD: begin
                div_start = pipe_idle;
                div_num   = NUM_W'({sum_mag, 1'b0}) + NUM_W'(bs_reg);
                div_den   = DEN_W'({bs_reg, 1'b0});
            end
            S_CP_SQD: begin
                div_start = pipe_idle;
                div_num   = NUM_W'({sq_acc_reg, 1'b0}) + NUM_W'(bs_reg);
                div_den   = DEN_W'({bs_reg, 1'b0});
            end
            default: ;
        endcase
    end

    // streaming pipeline for the two passes: read and sum; read, deviation, square, add
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cp_issue;
            v2_reg <= v1_reg && sq_pass;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (v1_reg && sum_pass) begin
            sum_reg <= sum_reg + SUM_W'(signed'(store_q_reg));
        end
        if ((v1_reg && sq_pass) || (state_reg == S_RD_FETCH)) begin
            d_reg <= d_fetch;
        end
        if (v2_reg) begin
            prod_reg <= $unsigned(prod_full);
        end
        if (v3_reg) begin
            sq_acc_reg <= sq_acc_reg + SQ_W'(prod_reg);
        end
        if (state_reg == S_RD_FETCH) begin
            rd_mean_reg <= mean_q_reg;
            rd_var_reg  <= var_q_reg;
        end
        // clear accumulators at the start of each channel's passes
        if ((state_reg == S_IDLE) || ((state_reg == S_CP_VDIV) && div_done)) begin
            sum_reg <= '0;
        end
        if ((state_reg == S_CP_MDIV) && div_done) begin
            sq_acc_reg   <= '0;
            mean_val_reg <= sum_reg[SUM_W-1] ? 16'(-div_quot[15:0]) : div_quot[15:0];
        end
    end

    // ------------------------------------------------------------------
    // result holding and output register
    // ------------------------------------------------------------------
    logic [bnf_pkg::NORM_W-1:0]   res_norm_reg;
    logic [bnf_pkg::AVG_W-1:0]    res_avg_reg;
    logic [bnf_pkg::SPREAD_W-1:0] res_spread_reg;
    logic [bnf_pkg::STATUS_W-1:0] res_status_reg;
    logic [bnf_pkg::NORM_W-1:0]   norm_sat;
    logic                         m_valid_reg;
    logic [bnf_pkg::NORM_W-1:0]   m_norm_reg;
    logic [bnf_pkg::AVG_W-1:0]    m_avg_reg;
    logic [bnf_pkg::SPREAD_W-1:0] m_spread_reg;
    logic [bnf_pkg::STATUS_W-1:0] m_status_reg;
    logic                         out_free;

    // round-away quotient, signed and clamped to Q4.12
    always_comb begin
        if (d_reg[16]) begin
            norm_sat = (div_quot > NUM_W'(32768)) ? 16'h8000 : 16'(-div_quot[15:0]);
        end else begin
            norm_sat = (div_quot > NUM_W'(32767)) ? 16'h7FFF : div_quot[15:0];
        end
    end

    assign out_free = !m_valid_reg || m_ready;

    // sequencer
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= S_IDLE;
            stats_ready_reg <= 1'b0;
            m_valid_reg     <= 1'b0;
        end else begin
            if (m_valid_reg && m_ready) begin
                m_valid_reg <= 1'b0;
            end
            if (cfg_fire && cfg_known) begin
                stats_ready_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (in_fire) begin
                        res_norm_reg   <= '0;
                        res_avg_reg    <= '0;
                        res_spread_reg <= '0;
                        res_status_reg <= bnf_pkg::ST_OK;
                        rd_addr_reg    <= pos_addr;
                        state_reg      <= S_EMIT;
                        if (s_operation == bnf_pkg::OP_NOP) begin
                            res_status_reg <= bnf_pkg::ST_OK;
                        end else if (over_cap) begin
                            res_status_reg <= bnf_pkg::ST_CAPACITY;
                        end else if (s_operation == bnf_pkg::OP_COMPUTE) begin
                            if (total_reg == '0) begin
                                res_status_reg <= bnf_pkg::ST_BAD_POS;
                            end else begin
                                ch_reg        <= '0;
                                chan_base_reg <= '0;
                                row_base_reg  <= '0;
                                s_cnt_reg     <= '0;
                                b_cnt_reg     <= '0;
                                state_reg     <= S_CP_SUM;
                            end
                        end else if (pos_out) begin
                            res_status_reg <= bnf_pkg::ST_BAD_POS;
                        end else if (s_operation == bnf_pkg::OP_READ) begin
                            if (!stats_ready_reg) begin
                                res_status_reg <= bnf_pkg::ST_NO_STATS;
                            end else begin
                                state_reg <= S_RD_QUOT;
                            end
                        end
                    end
                end
                S_EMIT: begin
                    if (out_free) begin
                        m_valid_reg  <= 1'b1;
                        m_norm_reg   <= res_norm_reg;
                        m_avg_reg    <= res_avg_reg;
                        m_spread_reg <= res_spread_reg;
                        m_status_reg <= res_status_reg;
                        state_reg    <= S_IDLE;
                    end
                end
                S_RD_QUOT: begin
                    if (div_done) begin
                        state_reg <= S_RD_CHAN;
                    end
                end
                S_RD_CHAN: begin
                    // channel index appears on the remainder; tables read it
                    if (div_done) begin
                        state_reg <= S_RD_FETCH;
                    end
                end
                S_RD_FETCH: begin
                    state_reg <= S_RD_ROOT;
                end
                S_RD_ROOT: begin
                    if (root_ctl_out.done) begin
                        state_reg <= S_RD_NORM;
                    end
                end
                S_RD_NORM: begin
                    if (div_done) begin
                        res_norm_reg   <= norm_sat;
                        res_avg_reg    <= rd_mean_reg;
                        res_spread_reg <= rd_var_reg;
                        state_reg      <= S_EMIT;
                    end
                end
                S_CP_SUM, S_CP_SQ: begin
                    // advance through the channel's rows, one element a cycle
                    if (row_end) begin
                        s_cnt_reg <= '0;
                        if (cp_last) begin
                            state_reg <= (state_reg == S_CP_SUM) ? S_CP_SUMD : S_CP_SQD;
                        end else begin
                            b_cnt_reg    <= b_cnt_reg + 1'b1;
                            row_base_reg <= row_base_reg + AW'(cs_reg);
                        end
                    end else begin
                        s_cnt_reg <= s_cnt_reg + 1'b1;
                    end
                end
                S_CP_SUMD: begin
                    if (pipe_idle) begin
                        state_reg <= S_CP_MDIV;
                    end
                end
                S_CP_MDIV: begin
                    if (div_done) begin
                        row_base_reg <= chan_base_reg;
                        s_cnt_reg    <= '0;
                        b_cnt_reg    <= '0;
                        state_reg    <= S_CP_SQ;
                    end
                end
                S_CP_SQD: begin
                    if (pipe_idle) begin
                        state_reg <= S_CP_VDIV;
                    end
                end
                S_CP_VDIV: begin
                    if (div_done) begin
                        if (ch_reg == chan_reg - 1'b1) begin
                            stats_ready_reg <= 1'b1;
                            state_reg       <= S_EMIT;
                        end else begin
                            ch_reg        <= ch_reg + 1'b1;
                            chan_base_reg <= chan_base_reg + AW'(spat_reg);
                            row_base_reg  <= chan_base_reg + AW'(spat_reg);
                            s_cnt_reg     <= '0;
                            b_cnt_reg     <= '0;
                            state_reg     <= S_CP_SUM;
                        end
                    end
                end
                default: begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_normalized      = m_norm_reg;
    assign m_channel_average = m_avg_reg;
    assign m_channel_spread  = m_spread_reg;
    assign m_status          = m_status_reg;

endmodule
